/* hw/rtl/irs_pkg.sv */
// Package for the two-zone irrigation scheduler: command and phase codes,
// configuration register indexes, reset values and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package irs_pkg;

    localparam int unsigned ELAPSED_W   = 14;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Configuration reset values
    localparam logic [4:0] RST_START_HOUR   = 5'd17;
    localparam logic [5:0] RST_START_MINUTE = 6'd0;
    localparam logic [7:0] RST_DURATION     = 8'd20;
    localparam logic [6:0] RST_DAY_MASK     = 7'h7F;

    // Weekday code that has no mask bit
    localparam logic [2:0] WEEKDAY_NONE = 3'd7;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_Z1_ON  = 3'd1,
        CMD_Z1_OFF = 3'd2,
        CMD_Z2_ON  = 3'd3,
        CMD_Z2_OFF = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_ZONE1 = 4'b0010,
        PH_PAUSE = 4'b0100,
        PH_ZONE2 = 4'b1000
    } t_phase;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_HOUR   = 2'd0,
        CFG_START_MINUTE = 2'd1,
        CFG_DURATION     = 2'd2,
        CFG_DAY_MASK     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [7:0] duration_minutes;
        logic [6:0] day_enable_mask;
    } t_cfg;

endpackage

/* hw/rtl/irs_cfg.sv */
// Configuration register file of the irrigation scheduler.
// Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [irs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [irs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output irs_pkg::t_cfg                   o_cfg
);
    import irs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode one write transfer into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_HOUR:   n_cfg.start_hour       = i_cfg_data[4:0];
                CFG_START_MINUTE: n_cfg.start_minute     = i_cfg_data[5:0];
                CFG_DURATION:     n_cfg.duration_minutes = i_cfg_data[7:0];
                CFG_DAY_MASK:     n_cfg.day_enable_mask  = i_cfg_data[6:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_hour       <= RST_START_HOUR;
            r_cfg.start_minute     <= RST_START_MINUTE;
            r_cfg.duration_minutes <= RST_DURATION;
            r_cfg.day_enable_mask  <= RST_DAY_MASK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/irs_sched.sv */
// Schedule state (phase, counting flag, seconds counter) and the per-tick
// step logic producing the zone command. Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_sched (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_time_valid,
    input  logic [2:0]    i_weekday,
    input  logic [4:0]    i_hour,
    input  logic [5:0]    i_minute,
    input  irs_pkg::t_cfg i_cfg,
    output irs_pkg::t_cmd o_cmd
);
    import irs_pkg::*;

    t_phase               r_phase,    n_phase;
    logic                 r_counting, n_counting;
    logic [ELAPSED_W-1:0] r_elapsed,  n_elapsed;

    logic [ELAPSED_W-1:0] limit;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 enabled;
    logic                 done;
    t_cmd                 cmd;

    // Threshold in seconds: duration * 60 as (d << 6) - (d << 2)
    assign limit = {i_cfg.duration_minutes, 6'b0} - {4'b0, i_cfg.duration_minutes, 2'b0};

    // Saturating advance while counting
    assign elapsed_inc = (r_counting && (r_elapsed != ELAPSED_MAX))
                         ? r_elapsed + 1'b1 : r_elapsed;

    assign enabled = (i_weekday != WEEKDAY_NONE) && i_cfg.day_enable_mask[i_weekday];
    assign done    = (elapsed_inc >= limit);

    // Phase step for one tick
    always_comb begin
        n_phase    = r_phase;
        n_counting = r_counting;
        n_elapsed  = r_elapsed;
        cmd        = CMD_NONE;
        if (i_time_valid) begin
            n_elapsed = elapsed_inc;
            if (enabled) begin
                unique case (r_phase)
                    PH_WAIT: begin
                        if ((i_hour == i_cfg.start_hour) && (i_minute == i_cfg.start_minute)) begin
                            cmd        = CMD_Z1_ON;
                            n_counting = 1'b1;
                            n_elapsed  = '0;
                            n_phase    = PH_ZONE1;
                        end
                    end
                    PH_ZONE1: begin
                        if (done) begin
                            cmd        = CMD_Z1_OFF;
                            n_counting = 1'b0;
                            n_phase    = PH_PAUSE;
                        end
                    end
                    PH_PAUSE: begin
                        if (done) begin
                            cmd        = CMD_Z2_ON;
                            n_counting = 1'b1;
                            n_elapsed  = '0;
                            n_phase    = PH_ZONE2;
                        end
                    end
                    PH_ZONE2: begin
                        if (done) begin
                            cmd        = CMD_Z2_OFF;
                            n_counting = 1'b0;
                            n_elapsed  = '0;
                            n_phase    = PH_WAIT;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_counting <= 1'b0;
            r_elapsed  <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_counting <= n_counting;
            r_elapsed  <= n_elapsed;
        end
    end

    assign o_cmd = cmd;

    // Counting only happens while a zone is watering
    a_count_in_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counting |-> (r_phase == PH_ZONE1 || r_phase == PH_ZONE2))
        else $error("counter running outside a watering phase");

    // Waiting for the start time always leaves the counter cleared
    a_wait_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_elapsed == '0 && !r_counting))
        else $error("counter not cleared while waiting");

    // A zone-on command restarts the counter from zero
    a_on_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (cmd == CMD_Z1_ON || cmd == CMD_Z2_ON)) |=>
        (r_elapsed == '0 && r_counting))
        else $error("zone on without counter restart");

endmodule

/* hw/rtl/two_zone_irrigation_scheduler.sv */
// Two-zone irrigation scheduler, top level.
// Ticks pass through the input register and then the result register, which drives the result channel.
// Throughput: one tick per cycle while the result channel is not stalled.
// Reset: synchronous active-low i_rst_n clears the valid flags of both pipeline registers and
// the schedule state, and loads the configuration reset values. Configuration is always ready.
// Depends on irs_pkg, irs_cfg, irs_sched.
`timescale 1ns / 1ps

module two_zone_irrigation_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_time_valid,
    input  logic [2:0]                      i_weekday,
    input  logic [4:0]                      i_hour,
    input  logic [5:0]                      i_minute,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_zone_command,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [irs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [irs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import irs_pkg::*;

    // Input register
    logic       r_in_valid;
    logic       r_time_valid;
    logic [2:0] r_weekday;
    logic [4:0] r_hour;
    logic [5:0] r_minute;

    // Result register
    logic       r_out_valid;
    t_cmd       r_cmd;

    logic       step;
    t_cfg       cfg;
    t_cmd       cmd;

    // Tick moves to the result register when that is free or being drained
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_time_valid <= i_time_valid;
            r_weekday    <= i_weekday;
            r_hour       <= i_hour;
            r_minute     <= i_minute;
        end
    end

    assign o_cfg_ready = 1'b1;

    irs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    irs_sched u_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_time_valid (r_time_valid),
        .i_weekday    (r_weekday),
        .i_hour       (r_hour),
        .i_minute     (r_minute),
        .i_cfg        (cfg),
        .o_cmd        (cmd)
    );

    // Result register: holds until the transfer out completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_cmd <= cmd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_zone_command = r_cmd;

    // A stalled result is never overwritten by the next tick
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !step)
        else $error("result overwritten while stalled");

    // The input register only empties by moving its tick forward
    a_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> r_in_valid)
        else $error("tick lost from input register");

    // Every forwarded tick yields a result next cycle
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("forwarded tick without result");

endmodule
